/* hdl/lower_triangular_forward_solve_core_defines.svh */
// Assertion macros shared by the forward-solve RTL.
// Needs signals named clock and reset in the including module.
`ifndef LOWER_TRIANGULAR_FORWARD_SOLVE_CORE_DEFINES_SVH
`define LOWER_TRIANGULAR_FORWARD_SOLVE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LTFS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ltfs assertion failed");
`define LTFS_NEVER(lbl, cond) `LTFS_ASSERT(lbl, !(cond))
`else
`define LTFS_ASSERT(lbl, prop)
`define LTFS_NEVER(lbl, cond)
`endif
`endif

/* hdl/ltfs_pkg.sv */
// Types and constants of the lower-triangular forward solver.
// No dependencies.
package ltfs_pkg;

   localparam int DATA_W      = 32;
   localparam int ROW_W       = 4;
   localparam int SIZE_W      = 5;
   localparam int STAT_W      = 2;
   localparam int QBITS       = 33;
   localparam int FRAC_W      = 16;
   localparam int MAX_SIZE_DEF = 16;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_SOLVE = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ZERO_DIAG = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_SAT       = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   typedef struct packed {
      logic                     req_type;
      logic [ROW_W-1:0]         row;
      logic [ROW_W-1:0]         col;
      logic signed [DATA_W-1:0] value;
   } ltfs_req_type;

   typedef struct packed {
      logic [ROW_W-1:0]         out_row;
      logic signed [DATA_W-1:0] solution_value;
      logic [STAT_W-1:0]        status;
      logic                     last_of_column;
   } ltfs_rsp_type;

   // divider result towards the sequencer
   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [DATA_W-1:0] quo;
   } ltfs_div_res_type;

endpackage

/* hdl/ltfs_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ltfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

/* hdl/ltfs_div.sv */
// Iterative restoring divider: Q16.16 quotient of accumulator by diagonal.
// One quotient bit per cycle, truncation toward zero, saturation. Uses ltfs_pkg.
module ltfs_div #(
   parameter int ACC_W = 53
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic signed [ACC_W-1:0]            num,
   input  logic signed [ltfs_pkg::DATA_W-1:0] den,
   output ltfs_pkg::ltfs_div_res_type         res
);
   import ltfs_pkg::*;

   typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_RUN, DV_FIN} dv_state_type;

   dv_state_type            state_ff;
   logic [ACC_W-1:0]        un_ff;
   logic [DATA_W-1:0]       ud_ff;
   logic                    neg_ff;
   logic                    ovf_ff;
   logic [DATA_W-1:0]       rem_ff;
   logic [QBITS-1:0]        sh_ff;
   logic [QBITS-1:0]        q_ff;
   logic [5:0]              cnt_ff;
   ltfs_div_res_type        res_ff;

   logic [DATA_W:0]         trial;
   logic                    fits;
   logic [QBITS-1:0]        limit;
   logic                    sat;

   // one restoring step
   assign trial = {rem_ff, sh_ff[QBITS-1]};
   assign fits  = trial >= {1'b0, ud_ff};
   assign limit = neg_ff ? QBITS'(33'h0_8000_0000) : QBITS'(33'h0_7FFF_FFFF);
   assign sat   = ovf_ff || (q_ff > limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= DV_IDLE;
         res_ff.done <= 1'b0;
      end else begin
         res_ff.done <= 1'b0;
         unique case (state_ff)
            DV_IDLE: begin
               if (go) begin
                  un_ff    <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
                  ud_ff    <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
                  neg_ff   <= num[ACC_W-1] ^ den[DATA_W-1];
                  state_ff <= DV_CHECK;
               end
            end
            DV_CHECK: begin
               // quotient of 2^33 or more cannot fit
               if ((un_ff >> (QBITS - FRAC_W)) >= ACC_W'(ud_ff)) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= DV_FIN;
               end else begin
                  ovf_ff   <= 1'b0;
                  rem_ff   <= DATA_W'(un_ff >> (QBITS - FRAC_W));
                  sh_ff    <= {un_ff[QBITS-FRAC_W-1:0], {FRAC_W{1'b0}}};
                  cnt_ff   <= 6'(QBITS - 1);
                  state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               rem_ff <= fits ? DATA_W'(trial - {1'b0, ud_ff}) : trial[DATA_W-1:0];
               q_ff   <= {q_ff[QBITS-2:0], fits};
               sh_ff  <= {sh_ff[QBITS-2:0], 1'b0};
               if (cnt_ff == 6'd0) begin
                  state_ff <= DV_FIN;
               end else begin
                  cnt_ff <= cnt_ff - 6'd1;
               end
            end
            DV_FIN: begin
               res_ff.done <= 1'b1;
               res_ff.sat  <= sat;
               if (sat) begin
                  res_ff.quo <= neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  res_ff.quo <= neg_ff ? DATA_W'(-q_ff) : q_ff[DATA_W-1:0];
               end
               state_ff <= DV_IDLE;
            end
            default: state_ff <= DV_IDLE;
         endcase
      end
   end

   assign res = res_ff;

endmodule

/* hdl/lower_triangular_forward_solve_core.sv */
// Top level of the lower-triangular forward solver (L*y = b, signed Q16.16).
// Uses ltfs_pkg, ltfs_ram, ltfs_div and the assertion macro header.
//
//   channel   ports                      transfer when
//   request   start, busy, req_payload   start high and busy low
//   result    rsp_valid, rsp_payload     rsp_valid high (one cycle)
//   config    csr_we, csr_wdata          csr_we high
//
// A matrix write leaves busy low. A solve for row r keeps busy high until its
// result is presented; busy falls in the same cycle that rsp_valid rises. The
// solve reads the r earlier unknowns and the diagonal, multiplies each earlier
// unknown with its matrix entry in the 32x32 multiplier, subtracts the products
// from the accumulator, then the divider takes the operands, checks for overflow,
// forms 33 quotient bits, finishes, and the result is registered. A quotient that
// cannot fit skips the quotient bits; a zero diagonal skips the divider.
// Reset is synchronous; stores are not cleared. Results cannot be stalled.
`include "lower_triangular_forward_solve_core_defines.svh"
module lower_triangular_forward_solve_core #(
   parameter int MAX_SIZE = ltfs_pkg::MAX_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  ltfs_pkg::ltfs_req_type       req_payload,
   output logic                         rsp_valid,
   output ltfs_pkg::ltfs_rsp_type       rsp_payload,
   input  logic                         csr_we,
   input  logic [ltfs_pkg::SIZE_W-1:0]  csr_wdata
);
   import ltfs_pkg::*;

   localparam int MDEPTH = MAX_SIZE * MAX_SIZE;
   localparam int MAW    = $clog2(MDEPTH);
   localparam int YAW    = $clog2(MAX_SIZE);
   localparam int ACC_W  = 49 + $clog2(MAX_SIZE);

   typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DIV} state_type;

   state_type                 state_ff;
   logic [SIZE_W-1:0]         size_ff;
   logic [ROW_W-1:0]          row_ff;
   logic                      last_ff;
   logic [ROW_W-1:0]          j_ff;
   logic                      iss_done_ff;
   logic                      s1_vld_ff;
   logic                      s1_diag_ff;
   logic                      p_vld_ff;
   logic signed [63:0]        prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [DATA_W-1:0]  d_ff;
   logic                      div_go_ff;
   logic                      rsp_valid_ff;
   ltfs_rsp_type              rsp_ff;

   logic [SIZE_W-1:0]         n_eff;
   logic                      accept;
   logic                      solve_ok;
   logic                      m_we;
   logic [MAW-1:0]            m_waddr;
   logic [MAW-1:0]            m_raddr;
   logic [DATA_W-1:0]         m_rdata;
   logic [DATA_W-1:0]         y_rdata;
   logic                      issue;
   logic                      mac_end;
   ltfs_div_res_type          div_res;

   // effective order of the matrix
   always_comb begin
      if (size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (32'(size_ff) > MAX_SIZE) begin
         n_eff = SIZE_W'(MAX_SIZE);
      end else begin
         n_eff = size_ff;
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign solve_ok = {1'b0, req_payload.row} < n_eff;

   // matrix store: written by requests, read by the sequencer
   assign m_we    = accept && (req_payload.req_type == REQ_WRITE)
                    && (32'(req_payload.row) < MAX_SIZE)
                    && (32'(req_payload.col) < MAX_SIZE);
   assign m_waddr = MAW'(32'(req_payload.row) * MAX_SIZE + 32'(req_payload.col));
   assign m_raddr = MAW'(32'(row_ff) * MAX_SIZE + 32'(j_ff));

   ltfs_ram #(.WIDTH(DATA_W), .DEPTH(MDEPTH)) u_mat (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (req_payload.value),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   // solved unknowns: written in the result cycle
   ltfs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_unk (
      .clock (clock),
      .we    (rsp_valid_ff),
      .waddr (YAW'(rsp_ff.out_row)),
      .wdata (rsp_ff.solution_value),
      .raddr (YAW'(j_ff)),
      .rdata (y_rdata)
   );

   ltfs_div #(.ACC_W(ACC_W)) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (acc_ff),
      .den   (d_ff),
      .res   (div_res)
   );

   assign issue   = (state_ff == ST_MAC) && !iss_done_ff;
   assign mac_end = (state_ff == ST_MAC) && iss_done_ff && !s1_vld_ff && !p_vld_ff;

   // sequencer, datapath and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         s1_vld_ff    <= 1'b0;
         p_vld_ff     <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iss_done_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         if (csr_we) begin
            size_ff <= csr_wdata;
         end

         // read, multiply and accumulate stages
         s1_vld_ff  <= issue;
         s1_diag_ff <= (j_ff == row_ff);
         p_vld_ff   <= s1_vld_ff && !s1_diag_ff;
         if (s1_vld_ff) begin
            if (s1_diag_ff) begin
               d_ff <= m_rdata;
            end else begin
               prod_ff <= $signed(m_rdata) * $signed(y_rdata);
            end
         end
         if (p_vld_ff) begin
            acc_ff <= acc_ff - ACC_W'(prod_ff >>> FRAC_W);
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_payload.req_type == REQ_SOLVE) && solve_ok) begin
                  row_ff      <= req_payload.row;
                  last_ff     <= ({1'b0, req_payload.row} == n_eff - SIZE_W'(1));
                  acc_ff      <= ACC_W'(req_payload.value);
                  j_ff        <= '0;
                  iss_done_ff <= 1'b0;
                  state_ff    <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (issue) begin
                  if (j_ff == row_ff) begin
                     iss_done_ff <= 1'b1;
                  end else begin
                     j_ff <= j_ff + ROW_W'(1);
                  end
               end
               if (mac_end) begin
                  if (d_ff == '0) begin
                     rsp_valid_ff          <= 1'b1;
                     rsp_ff.out_row        <= row_ff;
                     rsp_ff.solution_value <= '0;
                     rsp_ff.status         <= STATUS_ZERO_DIAG;
                     rsp_ff.last_of_column <= last_ff;
                     state_ff              <= ST_IDLE;
                  end else begin
                     div_go_ff <= 1'b1;
                     state_ff  <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (div_res.done) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.out_row        <= row_ff;
                  rsp_ff.solution_value <= div_res.quo;
                  rsp_ff.status         <= div_res.sat ? STATUS_SAT : STATUS_OK;
                  rsp_ff.last_of_column <= last_ff;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `LTFS_ASSERT(a_rsp_after_busy, rsp_valid |-> $past(busy))
   `LTFS_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid)
   `LTFS_ASSERT(a_zero_diag_val, rsp_valid && (rsp_payload.status == STATUS_ZERO_DIAG) |-> rsp_payload.solution_value == '0)
   `LTFS_ASSERT(a_write_no_busy, accept && (req_payload.req_type == REQ_WRITE) |=> !busy)
   `LTFS_NEVER(a_issue_past_diag, issue && (j_ff > row_ff))

endmodule
